@@ src/pim_pkg.sv @@
package pim_pkg;

    localparam int WORD_W      = 64;
    localparam int IDX_W       = 17;
    localparam int MAX_LEN     = 65536;
    localparam int BIT_CNT_W   = $clog2(WORD_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [IDX_W-1:0]     IDX_LIMIT = IDX_W'(MAX_LEN - 1);
    localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(WORD_W - 1);

    typedef struct packed {
        logic [WORD_W-1:0] coeff_in;
        logic              last_in;
    } in_item_t;

    typedef struct packed {
        logic [WORD_W-1:0] coeff_out;
        logic              last_out;
        logic              no_inverse;
    } out_item_t;

    // one queued coefficient with its index
    typedef struct packed {
        logic [WORD_W-1:0] coeff;
        logic              last;
        logic [IDX_W-1:0]  idx;
        logic              first;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_RED_C,
        ST_RED_D,
        ST_GCD_CHK,
        ST_GCD,
        ST_UPD,
        ST_FIX,
        ST_NEG,
        ST_MUL_D,
        ST_MUL_A,
        ST_OUT
    } back_state_t;

    // (a + b) mod n for a, b < n
    function automatic logic [WORD_W-1:0] add_mod(
        input logic [WORD_W-1:0] a,
        input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] n
    );
        logic [WORD_W-1:0] gap;
        gap = n - b;
        return (a >= gap) ? (a - gap) : (a + b);
    endfunction

endpackage

@@ src/pim_queue.sv @@
module pim_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pim_pkg::job_t     push_data,
    input  logic              pop,
    output pim_pkg::job_t     pop_data,
    output pim_pkg::q_status_t status
);

    pim_pkg::job_t                    mem_reg [pim_pkg::QUEUE_DEPTH];
    logic [pim_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [pim_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [pim_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_push, do_pop;

    assign status.full  = (count_reg == pim_pkg::QCNT_W'(pim_pkg::QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign pop_data     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == pim_pkg::QPTR_W'(pim_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == pim_pkg::QPTR_W'(pim_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ src/pim_front.sv @@
module pim_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  pim_pkg::in_item_t  in_data,
    input  pim_pkg::q_status_t q_status,
    output logic               push,
    output pim_pkg::job_t      push_data
);

    logic [pim_pkg::IDX_W-1:0] idx_reg, idx_next;

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        push_data.coeff = in_data.coeff_in;
        push_data.last  = in_data.last_in;
        push_data.idx   = idx_reg;
        push_data.first = (idx_reg == '0);
    end

    // index saturates at the length limit, returns to zero after a last mark
    always_comb
    begin
        idx_next = idx_reg;
        if (push)
        begin
            if (in_data.last_in)
            begin
                idx_next = '0;
            end
            else if (idx_reg < pim_pkg::IDX_LIMIT)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

@@ src/pim_back.sv @@
module pim_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [pim_pkg::WORD_W-1:0]  modulus,
    input  pim_pkg::q_status_t          q_status,
    input  pim_pkg::job_t               pop_data,
    output logic                        pop,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pim_pkg::out_item_t          out_data
);

    localparam int W = pim_pkg::WORD_W;

    pim_pkg::back_state_t state_reg, state_next;

    logic                           out_valid_reg, out_valid_next;
    pim_pkg::out_item_t             out_data_reg, out_data_next;

    logic [W-1:0]                   coeff_reg, coeff_next;
    logic                           last_reg, last_next;
    logic                           first_reg, first_next;
    logic [pim_pkg::IDX_W-1:0]      idx_reg, idx_next;

    logic [W-1:0]                   dvd_reg, dvd_next;
    logic [W-1:0]                   rem_reg, rem_next;
    logic [W-1:0]                   dvs_reg, dvs_next;
    logic [pim_pkg::BIT_CNT_W-1:0]  cnt_reg, cnt_next;

    logic [W-1:0]                   r0_reg, r0_next;
    logic [W-1:0]                   r1_reg, r1_next;
    logic [W-1:0]                   s0_reg, s0_next;
    logic [W-1:0]                   s1_reg, s1_next;
    logic [W-1:0]                   acc_reg, acc_next;
    logic                           odd_reg, odd_next;
    logic                           fail_reg, fail_next;

    logic                           out_free;
    logic                           load_lead;
    logic                           load_res;
    logic [W:0]                     shifted;
    logic [W:0]                     diff;
    logic                           ge;
    logic [W-1:0]                   rem_step;
    logic [W-1:0]                   dvd_step;
    logic [W-1:0]                   acc_step;
    logic                           cnt_end;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cnt_end   = (cnt_reg == pim_pkg::BIT_LAST);

    // one restoring division bit, with the quotient times s1 built alongside
    assign shifted  = {rem_reg, dvd_reg[W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign ge       = (shifted >= {1'b0, dvs_reg});
    assign rem_step = ge ? diff[W-1:0] : shifted[W-1:0];
    assign dvd_step = {dvd_reg[W-2:0], ge};
    assign acc_step = {acc_reg[W-2:0], 1'b0} + (ge ? s1_reg : '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pim_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    state_next = pim_pkg::ST_START;
                end
            end
            pim_pkg::ST_START:
            begin
                if (!first_reg || out_free)
                begin
                    state_next = (modulus == '0) ? pim_pkg::ST_OUT : pim_pkg::ST_RED_C;
                end
            end
            pim_pkg::ST_RED_C:
            begin
                if (cnt_end)
                begin
                    state_next = pim_pkg::ST_RED_D;
                end
            end
            pim_pkg::ST_RED_D:
            begin
                if (cnt_end)
                begin
                    state_next = pim_pkg::ST_GCD_CHK;
                end
            end
            pim_pkg::ST_GCD_CHK:
            begin
                state_next = (r1_reg == '0) ? pim_pkg::ST_FIX : pim_pkg::ST_GCD;
            end
            pim_pkg::ST_GCD:
            begin
                if (cnt_end)
                begin
                    state_next = pim_pkg::ST_UPD;
                end
            end
            pim_pkg::ST_UPD:   state_next = pim_pkg::ST_GCD_CHK;
            pim_pkg::ST_FIX:   state_next = pim_pkg::ST_NEG;
            pim_pkg::ST_NEG:
                state_next = (r0_reg == W'(1)) ? pim_pkg::ST_MUL_D : pim_pkg::ST_OUT;
            pim_pkg::ST_MUL_D: state_next = pim_pkg::ST_MUL_A;
            pim_pkg::ST_MUL_A: state_next = cnt_end ? pim_pkg::ST_OUT : pim_pkg::ST_MUL_D;
            pim_pkg::ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = pim_pkg::ST_IDLE;
                end
            end
            default:  state_next = pim_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        pop            = 1'b0;
        load_lead      = 1'b0;
        load_res       = 1'b0;
        coeff_next     = coeff_reg;
        last_next      = last_reg;
        first_next     = first_reg;
        idx_next       = idx_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        cnt_next       = cnt_reg;
        r0_next        = r0_reg;
        r1_next        = r1_reg;
        s0_next        = s0_reg;
        s1_next        = s1_reg;
        acc_next       = acc_reg;
        odd_next       = odd_reg;
        fail_next      = fail_reg;
        unique case (state_reg)
            pim_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop        = 1'b1;
                    coeff_next = pop_data.coeff;
                    last_next  = pop_data.last;
                    first_next = pop_data.first;
                    idx_next   = pop_data.idx;
                end
            end
            pim_pkg::ST_START:
            begin
                if (!first_reg || out_free)
                begin
                    load_lead = first_reg;
                    acc_next  = '0;
                    fail_next = (modulus == '0);
                    dvd_next  = coeff_reg;
                    rem_next  = '0;
                    dvs_next  = modulus;
                    cnt_next  = '0;
                end
            end
            pim_pkg::ST_RED_C:
            begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end)
                begin
                    coeff_next = rem_step;
                    dvd_next   = W'({1'b0, idx_reg} + 1'b1);
                    rem_next   = '0;
                end
            end
            pim_pkg::ST_RED_D:
            begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_end)
                begin
                    r0_next  = modulus;
                    r1_next  = rem_step;
                    s0_next  = '0;
                    s1_next  = W'(1);
                    odd_next = 1'b0;
                end
            end
            pim_pkg::ST_GCD_CHK:
            begin
                dvd_next = r0_reg;
                dvs_next = r1_reg;
                rem_next = '0;
                acc_next = '0;
                cnt_next = '0;
            end
            pim_pkg::ST_GCD:
            begin
                dvd_next = dvd_step;
                rem_next = rem_step;
                acc_next = acc_step;
                cnt_next = cnt_reg + 1'b1;
            end
            pim_pkg::ST_UPD:
            begin
                r0_next  = r1_reg;
                r1_next  = rem_reg;
                s0_next  = s1_reg;
                s1_next  = s0_reg + acc_reg;
                odd_next = !odd_reg;
            end
            pim_pkg::ST_FIX:
            begin
                if (s0_reg >= modulus)
                begin
                    s0_next = s0_reg - modulus;
                end
            end
            pim_pkg::ST_NEG:
            begin
                acc_next  = '0;
                cnt_next  = '0;
                fail_next = (r0_reg != W'(1));
                s1_next   = (!odd_reg && s0_reg != '0) ? (modulus - s0_reg) : s0_reg;
            end
            pim_pkg::ST_MUL_D:
            begin
                acc_next = pim_pkg::add_mod(acc_reg, acc_reg, modulus);
            end
            pim_pkg::ST_MUL_A:
            begin
                if (s1_reg[W-1])
                begin
                    acc_next = pim_pkg::add_mod(acc_reg, coeff_reg, modulus);
                end
                s1_next  = {s1_reg[W-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
            end
            pim_pkg::ST_OUT:
            begin
                load_res = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (load_lead)
        begin
            out_valid_next           = 1'b1;
            out_data_next.coeff_out  = '0;
            out_data_next.last_out   = 1'b0;
            out_data_next.no_inverse = 1'b0;
        end
        else if (load_res)
        begin
            out_valid_next           = 1'b1;
            out_data_next.coeff_out  = fail_reg ? '0 : acc_reg;
            out_data_next.last_out   = last_reg;
            out_data_next.no_inverse = fail_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pim_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        coeff_reg    <= coeff_next;
        last_reg     <= last_next;
        first_reg    <= first_next;
        idx_reg      <= idx_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        dvs_reg      <= dvs_next;
        cnt_reg      <= cnt_next;
        r0_reg       <= r0_next;
        r1_reg       <= r1_next;
        s0_reg       <= s0_next;
        s1_reg       <= s1_next;
        acc_reg      <= acc_next;
        odd_reg      <= odd_next;
        fail_reg     <= fail_next;
    end

endmodule

@@ src/poly_integral_mod_n.sv @@
// formal integral of a polynomial mod n, one coefficient per item, lowest degree
// first. every item gives c_i * (i+1)^-1 mod n; the first item of a polynomial is
// preceded by a leading 0 result. when i+1 has no inverse mod n the result is 0 with
// no_inverse set, and modulus 0 flags every divided coefficient. the index runs up
// to 65535 and then holds, and returns to 0 after an item with last_in. items are
// queued two deep in front of a sequential engine built on one shared bit-serial
// divider: reduce the coefficient, reduce i+1, run the extended-gcd steps (one
// division and one update each), then a double-and-add modular multiply. the
// number of gcd steps for i+1 against n is at most about 93 for a 64-bit modulus.
// the modulus is written through the cfg channel, always ready, and must only
// change while idle.
module poly_integral_mod_n (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pim_pkg::in_item_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pim_pkg::out_item_t          out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [pim_pkg::WORD_W-1:0]  cfg_data
);

    logic [pim_pkg::WORD_W-1:0] modulus_reg, modulus_next;
    pim_pkg::q_status_t         q_status;
    pim_pkg::job_t              push_data;
    pim_pkg::job_t              pop_data;
    logic                       push;
    logic                       pop;

    // modulus register, reset to one
    assign cfg_ready = 1'b1;

    always_comb
    begin
        modulus_next = modulus_reg;
        if (cfg_valid && cfg_ready)
        begin
            modulus_next = cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= pim_pkg::WORD_W'(1);
        end
        else
        begin
            modulus_reg <= modulus_next;
        end
    end

    // front: index tracking and classification of the first coefficient
    pim_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    // short queue between front and back
    pim_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    // back: reduction, inverse and multiply, output register
    pim_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .modulus   (modulus_reg),
        .q_status  (q_status),
        .pop_data  (pop_data),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // a flagged coefficient always reads as zero
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.no_inverse |-> out_data.coeff_out == '0)
        else $error("flagged coefficient not zero");

    // the front only stalls when the queue is full
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> q_status.full)
        else $error("input stalled with room in queue");

    // the back never pops an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

@@ sim/poly_integral_mod_n_test.sv @@
module poly_integral_mod_n_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    pim_pkg::in_item_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    pim_pkg::out_item_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [pim_pkg::WORD_W-1:0] cfg_data = '0;

    localparam logic [pim_pkg::WORD_W-1:0] ALL_ONES    = '1;
    localparam logic [pim_pkg::WORD_W-1:0] BIG_PRIME   = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam int                         DRAIN_WAIT  = 8000;

    always #5 clk = ~clk;

    poly_integral_mod_n dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // predictor state: our own copy of the modulus and the running index
    logic [pim_pkg::WORD_W-1:0] ring_mod = 64'd1;
    logic [pim_pkg::IDX_W-1:0]  next_index = '0;
    pim_pkg::out_item_t         pending_coeffs[$];
    bit                         failed = 1'b0;

    // sender burst shaping
    int  burst_left = 0;
    bit  sender_idles = 1'b1;

    // extended gcd inverse of a mod n, with unsigned 64-bit wraparound
    function automatic logic [pim_pkg::WORD_W-1:0] mod_inverse(
        input logic [pim_pkg::WORD_W-1:0] a,
        input logic [pim_pkg::WORD_W-1:0] n,
        output bit                        found
    );
        logic [pim_pkg::WORD_W-1:0] r0, r1, r2, s0, s1, s2, q;
        int                         steps;
        r0 = n;
        r1 = a;
        s0 = '0;
        s1 = 64'd1;
        steps = 0;
        while (r1 != 0)
        begin
            q  = r0 / r1;
            r2 = r0 - q * r1;
            s2 = s0 + q * s1;
            r0 = r1;
            r1 = r2;
            s0 = s1;
            s1 = s2;
            steps++;
        end
        if (r0 != 64'd1)
        begin
            found = 1'b0;
            return '0;
        end
        s0 = s0 % n;
        if (steps[0] == 1'b0 && s0 != 0)
            s0 = n - s0;
        found = 1'b1;
        return s0;
    endfunction

    // expected integral coefficients for one accepted input item
    task automatic predict_integral(input pim_pkg::in_item_t item);
        pim_pkg::out_item_t           res;
        logic [pim_pkg::WORD_W-1:0]   divisor, inv, c;
        logic [2*pim_pkg::WORD_W-1:0] prod;
        bit                           found;
        if (next_index == 0)
            pending_coeffs.push_back('{coeff_out: '0, last_out: 1'b0, no_inverse: 1'b0});
        res = '{coeff_out: '0, last_out: item.last_in, no_inverse: 1'b1};
        if (ring_mod != 0)
        begin
            divisor = (pim_pkg::WORD_W'(next_index) + 64'd1) % ring_mod;
            c = item.coeff_in % ring_mod;
            inv = mod_inverse(divisor, ring_mod, found);
            if (found)
            begin
                prod = c * inv;
                res.coeff_out = pim_pkg::WORD_W'(prod % ring_mod);
                res.no_inverse = 1'b0;
            end
        end
        pending_coeffs.push_back(res);
        if (item.last_in)
            next_index = '0;
        else if (next_index < pim_pkg::IDX_LIMIT)
            next_index = next_index + 1'b1;
    endtask

    // present one item, honoring sender gaps, and hold it until taken
    task automatic send_coeff(input pim_pkg::in_item_t item);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = sender_idles ? $urandom_range(0, 25) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic idle_sender();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // modulus changes only once the engine has drained
    task automatic write_modulus(input logic [pim_pkg::WORD_W-1:0] value);
        idle_sender();
        while (pending_coeffs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        ring_mod = value;
    endtask

    // directed rows: typed rows override the predicted divided coefficient
    typedef struct {
        logic [pim_pkg::WORD_W-1:0] modulus;
        logic [pim_pkg::WORD_W-1:0] coeff;
        logic                       last;
        bit                         typed;
        logic [pim_pkg::WORD_W-1:0] want_coeff;
        logic                       want_flag;
    } stim_row_t;

    localparam int N_ROWS = 21;
    stim_row_t stim_rows[N_ROWS] = '{
        // modulus one after reset, unreduced coefficient
        '{64'd1, ALL_ONES, 1'b0, 1'b1, 64'd0, 1'b0},
        '{64'd1, 64'd5,    1'b1, 1'b1, 64'd0, 1'b0},
        // modulus zero flags every divided coefficient
        '{64'd0, 64'd123,  1'b0, 1'b1, 64'd0, 1'b1},
        '{64'd0, ALL_ONES, 1'b1, 1'b1, 64'd0, 1'b1},
        // small prime, divisor wraps to zero at the seventh coefficient
        '{64'd7, 64'd3,    1'b0, 1'b1, 64'd3, 1'b0},
        '{64'd7, 64'd10,   1'b0, 1'b0, 64'd0, 1'b0},
        '{64'd7, 64'd6,    1'b0, 1'b0, 64'd0, 1'b0},
        '{64'd7, 64'd1,    1'b0, 1'b0, 64'd0, 1'b0},
        '{64'd7, 64'd0,    1'b0, 1'b1, 64'd0, 1'b0},
        '{64'd7, 64'd5,    1'b0, 1'b0, 64'd0, 1'b0},
        '{64'd7, 64'd4,    1'b1, 1'b1, 64'd0, 1'b1},
        // composite modulus, divisor 2 has no inverse
        '{64'd12, 64'd5,   1'b0, 1'b1, 64'd5, 1'b0},
        '{64'd12, 64'd7,   1'b0, 1'b1, 64'd0, 1'b1},
        '{64'd12, 64'd11,  1'b1, 1'b0, 64'd0, 1'b0},
        // largest modulus, coefficient equal to it reduces to zero
        '{ALL_ONES, ALL_ONES,      1'b0, 1'b1, 64'd0, 1'b0},
        '{ALL_ONES, ALL_ONES - 1,  1'b0, 1'b0, 64'd0, 1'b0},
        '{ALL_ONES, 64'd1,         1'b1, 1'b0, 64'd0, 1'b0},
        // large prime, extremes of the coefficient
        '{BIG_PRIME, BIG_PRIME - 1, 1'b0, 1'b1, BIG_PRIME - 1, 1'b0},
        '{BIG_PRIME, 64'd0,         1'b0, 1'b1, 64'd0, 1'b0},
        '{BIG_PRIME, ALL_ONES,      1'b0, 1'b0, 64'd0, 1'b0},
        '{BIG_PRIME, 64'h5555_AAAA_0F0F_F0F0, 1'b1, 1'b0, 64'd0, 1'b0}
    };

    function automatic logic [pim_pkg::WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // random moduli: a big prime, random odd, small, powers of two, any word, degenerate, all ones, mid-sized
    function automatic logic [pim_pkg::WORD_W-1:0] pick_modulus(input int phase);
        case (phase % 8)
            0: return BIG_PRIME;
            1: return rand_word() | 64'd1;
            2: return 64'($urandom_range(2, 40));
            3: return 64'd1 << $urandom_range(1, 63);
            4: return rand_word();
            5: return (phase % 16 == 5) ? 64'd0 : 64'd1;
            6: return ALL_ONES;
            default: return 64'($urandom_range(41, 100000));
        endcase
    endfunction

    // receiver stalls in changing modes
    int stall_mode = 0;
    int cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count % 64 == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom_range(0, 1) == 0);
            2: out_ready <= ($urandom_range(0, 3) == 0);
            default: out_ready <= ((cycle_count / 5) % 2 == 0);
        endcase
    end

    // compare each result with the oldest expectation
    always @(posedge clk)
    begin
        pim_pkg::out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_coeffs.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %h/%b/%b", $realtime,
                         out_data.coeff_out, out_data.last_out, out_data.no_inverse);
                failed = 1'b1;
            end
            else
            begin
                want = pending_coeffs.pop_front();
                if (out_data.coeff_out !== want.coeff_out)
                begin
                    $display("%0t: coeff_out expected %h, got %h", $realtime,
                             want.coeff_out, out_data.coeff_out);
                    failed = 1'b1;
                end
                if (out_data.last_out !== want.last_out)
                begin
                    $display("%0t: last_out expected %b, got %b", $realtime,
                             want.last_out, out_data.last_out);
                    failed = 1'b1;
                end
                if (out_data.no_inverse !== want.no_inverse)
                begin
                    $display("%0t: no_inverse expected %b, got %b", $realtime,
                             want.no_inverse, out_data.no_inverse);
                    failed = 1'b1;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        pim_pkg::in_item_t item;
        pim_pkg::out_item_t typed_res;
        int items_sent;
        int phase;
        int poly_len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, reset modulus first
        for (int r = 0; r < N_ROWS; r++)
        begin
            if (stim_rows[r].modulus != ring_mod)
                write_modulus(stim_rows[r].modulus);
            item.coeff_in = stim_rows[r].coeff;
            item.last_in  = stim_rows[r].last;
            send_coeff(item);
            predict_integral(item);
            if (stim_rows[r].typed)
            begin
                typed_res = '{coeff_out: stim_rows[r].want_coeff,
                              last_out: stim_rows[r].last,
                              no_inverse: stim_rows[r].want_flag};
                void'(pending_coeffs.pop_back());
                pending_coeffs.push_back(typed_res);
            end
        end

        // random phases, each under a new modulus, polynomials mostly short
        items_sent = 0;
        phase = 0;
        while (items_sent < 1650)
        begin
            write_modulus(pick_modulus(phase));
            sender_idles = (phase % 3 != 2);
            for (int p = 0; p < 12; p++)
            begin
                poly_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 12);
                for (int k = 0; k < poly_len; k++)
                begin
                    item.coeff_in = rand_word();
                    if (ring_mod != 0 && $urandom_range(0, 9) != 0)
                        item.coeff_in = item.coeff_in % ring_mod;
                    item.last_in = (k == poly_len - 1);
                    send_coeff(item);
                    predict_integral(item);
                    items_sent++;
                end
            end
            phase++;
        end
        idle_sender();

        while (pending_coeffs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (!failed)
            $display("[poly_integral_mod_n] OK");
        else
            $display("[poly_integral_mod_n] ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #400ms;
        $display("[poly_integral_mod_n] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
src/pim_pkg.sv
src/pim_queue.sv
src/pim_front.sv
src/pim_back.sv
src/poly_integral_mod_n.sv
sim/poly_integral_mod_n_test.sv
